// ===== hw/rtl/amsd_pkg.sv =====
// ----------------------------------------------------------------------------
// amsd_pkg: shared constants for the accelerometer shake detector
// Field widths, register reset value and default sample width.
// ----------------------------------------------------------------------------
package amsd_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned MagW           = 16;
  localparam int unsigned ChangeW        = 17;
  localparam int unsigned ThreshW        = 16;

  localparam logic [ThreshW-1:0] ThreshReset = 16'd24576;
  localparam logic [MagW-1:0]    MagMax      = 16'hFFFF;

  // Result item packing, lowest bit first.
  localparam int unsigned OutBits  = MagW + ChangeW + 1;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

endpackage

// ===== hw/rtl/amsd_isqrt.sv =====
// ----------------------------------------------------------------------------
// amsd_isqrt: iterative floor square root
// Shift and subtract root extraction, one result bit per cycle.
// ----------------------------------------------------------------------------
module amsd_isqrt #(
  parameter int unsigned SampleWidth = amsd_pkg::SampleWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [2*SampleWidth-1:0]   radicand_i,
  output logic                       done_o,
  output logic [SampleWidth-1:0]     root_o
);

  localparam int unsigned SumW = 2 * SampleWidth;
  localparam int unsigned RemW = SampleWidth + 1;
  localparam int unsigned CntW = $clog2(SampleWidth + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(SampleWidth - 1);

  logic [SumW-1:0]        rad_q, rad_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [SampleWidth-1:0] root_q, root_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  logic [RemW:0] rem_sh;
  logic [RemW:0] trial;
  logic          ge;

  // Bring in the next two radicand bits and try setting the next root bit.
  assign rem_sh = {rem_q[RemW-2:0], rad_q[SumW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[SumW-3:0], 2'b00};
      rem_d  = ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_d = {root_q[SampleWidth-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/accel_magnitude_shake_detector.sv =====
// ----------------------------------------------------------------------------
// accel_magnitude_shake_detector: three-axis magnitude and shake flag
// Each item is squared axis by axis on the shared squaring multiplier, then the
// sum goes to the bit-serial square root, which produces one root bit per cycle.
// A new item is taken only in the idle state, once the previous result is
// registered; the result register lets the next item start while one waits.
// Reset: threshold returns to 24576 and the previous magnitude to zero.
// ----------------------------------------------------------------------------
module accel_magnitude_shake_detector #(
  parameter int unsigned SampleWidth = amsd_pkg::SampleWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: shake_threshold.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [amsd_pkg::ThreshW-1:0]      cfg_data_i,
  // Input items.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata fields from bit 0: accel_x, accel_y, accel_z, zero padding.
  input  logic [((3*SampleWidth+7)/8)*8-1:0] s_axis_tdata_i,
  // Result items.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata fields from bit 0: magnitude, magnitude_change, shake_detected,
  // zero padding.
  output logic [amsd_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  localparam int unsigned SumW = 2 * SampleWidth;
  localparam int unsigned RootExtW = (SampleWidth > amsd_pkg::MagW) ?
                                     SampleWidth : amsd_pkg::MagW;
  localparam int unsigned MagW    = amsd_pkg::MagW;
  localparam int unsigned ChangeW = amsd_pkg::ChangeW;

  typedef enum logic [1:0] {
    StIdle,
    StSquare,
    StRoot,
    StFinish
  } state_e;

  state_e state_q;

  logic [SampleWidth-1:0] ax_q, ay_q, az_q;
  logic [1:0]             step_q;
  logic [SumW-1:0]        prod_q;
  logic [SumW-1:0]        acc_q;
  logic [SumW-1:0]        sum_d;
  logic [MagW-1:0]        mag_q;
  logic [MagW-1:0]        prev_q;
  logic [amsd_pkg::ThreshW-1:0] thresh_q;
  logic                   out_valid_q;
  logic [amsd_pkg::OutDataW-1:0] out_data_q;

  logic [SampleWidth-1:0] sel;
  logic [SampleWidth-1:0] sel_abs;
  logic                   root_start;
  logic                   root_done;
  logic [SampleWidth-1:0] root;
  logic [RootExtW-1:0]    root_ext;
  logic [MagW-1:0]        mag_sat;
  logic [ChangeW-1:0]     change;
  logic                   shake;
  logic                   out_free;

  assign s_axis_tready_o = (state_q == StIdle);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Shared squaring unit: one axis per cycle.
  always_comb begin
    case (step_q)
      2'd0:    sel = ax_q;
      2'd1:    sel = ay_q;
      default: sel = az_q;
    endcase
  end
  assign sel_abs = sel[SampleWidth-1] ? (~sel + 1'b1) : sel;
  assign sum_d   = acc_q + prod_q;

  assign root_start = (state_q == StSquare) && (step_q == 2'd3);

  amsd_isqrt #(
    .SampleWidth(SampleWidth)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_d),
    .done_o     (root_done),
    .root_o     (root)
  );

  // Roots above 16 bits only occur for wide samples and saturate.
  assign root_ext = RootExtW'(root);
  assign mag_sat  = (root_ext > RootExtW'(amsd_pkg::MagMax)) ?
                    amsd_pkg::MagMax : root_ext[MagW-1:0];

  assign change   = {1'b0, mag_q} - {1'b0, prev_q};
  assign shake    = !change[ChangeW-1] && (change[MagW-1:0] > thresh_q);
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      thresh_q    <= amsd_pkg::ThreshReset;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      // In the finish state a taken result is replaced by the new one below.
      if (out_valid_q && m_axis_tready_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid_i) begin
            step_q  <= '0;
            state_q <= StSquare;
          end
        end
        StSquare: begin
          step_q <= step_q + 1'b1;
          if (step_q == 2'd3) begin
            state_q <= StRoot;
          end
        end
        StRoot: begin
          if (root_done) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            prev_q      <= mag_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      ax_q  <= s_axis_tdata_i[SampleWidth-1:0];
      ay_q  <= s_axis_tdata_i[2*SampleWidth-1:SampleWidth];
      az_q  <= s_axis_tdata_i[3*SampleWidth-1:2*SampleWidth];
      acc_q <= '0;
    end
    if (state_q == StSquare) begin
      // The product of the previous axis is added while the next one squares.
      if (step_q != 2'd0) begin
        acc_q <= sum_d;
      end
      prod_q <= SumW'(sel_abs * sel_abs);
    end
    if (state_q == StIdle) begin
      prod_q <= '0;
    end
    if (root_done) begin
      mag_q <= mag_sat;
    end
    if ((state_q == StFinish) && out_free) begin
      out_data_q <= amsd_pkg::OutDataW'({shake, change, mag_q});
    end
  end

endmodule
